// ===== rtl/core/nme_pkg.sv =====
// ----------------------------------------------------------------------------
// nme_pkg: shared types, constants and coefficient tables
// Payload structs, sequencer states, the fixed 6-8-8 network coefficients in
// Q2.14 and the helpers used by the MLP datapath.
// ----------------------------------------------------------------------------
package nme_pkg;

  // Sizes fixed by the network and by the item format
  localparam int unsigned NEIGHBORS_DEF  = 6;
  localparam int unsigned INPUT_FEATURES = 6;
  localparam int unsigned HIDDEN_WIDTH   = 8;
  localparam int unsigned FEAT_W         = 16;
  localparam int unsigned EMB_W          = 15;
  localparam int unsigned SUM_W          = 20;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned PROD_W         = FEAT_W + 1 + COEF_W;
  localparam int unsigned ACC_W          = PROD_W + 1;
  localparam int unsigned FRAC_SHIFT     = 14;
  localparam int unsigned BIAS_SHIFT     = 10;
  localparam int unsigned ROUND_HALF     = 1 << (FRAC_SHIFT - 1);
  localparam int unsigned Q_MAX          = (1 << EMB_W) - 1;

  typedef struct packed {
    logic signed [FEAT_W-1:0] rel_pos_x;
    logic signed [FEAT_W-1:0] rel_pos_y;
    logic signed [FEAT_W-1:0] rel_pos_z;
    logic signed [FEAT_W-1:0] rel_vel_x;
    logic signed [FEAT_W-1:0] rel_vel_y;
    logic signed [FEAT_W-1:0] rel_vel_z;
  } in_item_t;

  typedef struct packed {
    logic [EMB_W-1:0] embed_0;
    logic [EMB_W-1:0] embed_1;
    logic [EMB_W-1:0] embed_2;
    logic [EMB_W-1:0] embed_3;
    logic [EMB_W-1:0] embed_4;
    logic [EMB_W-1:0] embed_5;
    logic [EMB_W-1:0] embed_6;
    logic [EMB_W-1:0] embed_7;
  } out_item_t;

  // One multiply-accumulate slot handed to the MLP datapath
  typedef struct packed {
    logic             vld;
    logic             out_layer;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } issue_t;

  // Finished output-layer neuron
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] row;
    logic [EMB_W-1:0] value;
  } mlp_res_t;

  // One step of the mean/clear sweep over the accumulators
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } sweep_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAYER0,
    S_DRAIN0,
    S_LAYER1,
    S_DRAIN1,
    S_HOLD,
    S_MEAN
  } state_t;

  localparam logic signed [COEF_W-1:0] L0_W [HIDDEN_WIDTH][INPUT_FEATURES] = '{
    '{ 16'sd8875, -16'sd11131, -16'sd10520,  16'sd1507, -16'sd3891, -16'sd2269},
    '{ 16'sd8531, -16'sd11593,  -16'sd7021, -16'sd2094,  16'sd5559, -16'sd3138},
    '{ 16'sd7548,  -16'sd9862,  -16'sd6108, -16'sd6173,  16'sd7427,  16'sd4243},
    '{ 16'sd8874,  -16'sd9398,   16'sd1347, -16'sd7363,  16'sd7329,    16'sd97},
    '{ -16'sd501,  -16'sd2177,   16'sd2264,  16'sd2753,  -16'sd614, -16'sd5649},
    '{-16'sd6747,   16'sd5336,   16'sd4370, -16'sd6709, -16'sd1635, -16'sd3595},
    '{16'sd13489,  -16'sd3215,   16'sd2082, -16'sd2584, -16'sd4278,  16'sd4363},
    '{ 16'sd5623,  -16'sd6170, -16'sd12927,  16'sd1402,  16'sd3621,  16'sd3601}
  };

  localparam logic signed [COEF_W-1:0] L0_B [HIDDEN_WIDTH] = '{
    16'sd1483, 16'sd2490, -16'sd1910, 16'sd360, 16'sd3465, 16'sd569, 16'sd1769, 16'sd2415
  };

  localparam logic signed [COEF_W-1:0] L1_W [HIDDEN_WIDTH][HIDDEN_WIDTH] = '{
    '{  -16'sd533, -16'sd6248,  16'sd3994, -16'sd5030, -16'sd2856,   16'sd5864,
        16'sd4803, -16'sd2173},
    '{    16'sd21,  16'sd3661,  16'sd5553, -16'sd9950,  16'sd5620, -16'sd11234,
      -16'sd19236, -16'sd5499},
    '{-16'sd13849, -16'sd9920, -16'sd9756,   16'sd661, -16'sd3478,  -16'sd4437,
       -16'sd3318,  16'sd4394},
    '{  16'sd5064,  16'sd2421, -16'sd9314,  16'sd6321, -16'sd2158,   16'sd8898,
       -16'sd3883, -16'sd8705},
    '{ -16'sd9693,   16'sd524,  16'sd6591,  16'sd6773,  -16'sd375,   -16'sd283,
       -16'sd4000, -16'sd7637},
    '{ -16'sd1293,  16'sd6107,  16'sd7517, -16'sd4868,  16'sd9332,  -16'sd3894,
       -16'sd3047, -16'sd13764},
    '{-16'sd12648, -16'sd8497,  16'sd8987, -16'sd2974,  16'sd7430,  -16'sd1306,
       -16'sd1235, -16'sd2633},
    '{-16'sd13396, -16'sd3403,  16'sd5982,  16'sd3148,   -16'sd12,    16'sd746,
       -16'sd2808, -16'sd7310}
  };

  localparam logic signed [COEF_W-1:0] L1_B [HIDDEN_WIDTH] = '{
    16'sd3421, 16'sd4003, 16'sd4555, 16'sd2451, -16'sd236, 16'sd1935, 16'sd3074, 16'sd4409
  };

  // Weight lookup for either layer
  function automatic logic signed [COEF_W-1:0] coef(input logic out_layer,
                                                    input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
    logic signed [COEF_W-1:0] w;
    if (out_layer) begin
      w = L1_W[row][col];
    end else if (col < IDX_W'(INPUT_FEATURES)) begin
      w = L0_W[row][col];
    end else begin
      w = '0;
    end
    return w;
  endfunction

  // Bias lookup for either layer
  function automatic logic signed [COEF_W-1:0] bias(input logic out_layer,
                                                    input logic [IDX_W-1:0] row);
    logic signed [COEF_W-1:0] b;
    if (out_layer) begin
      b = L1_B[row];
    end else begin
      b = L0_B[row];
    end
    return b;
  endfunction

  // Pick one input feature of the observation
  function automatic logic signed [FEAT_W-1:0] feature(input in_item_t item,
                                                       input logic [IDX_W-1:0] col);
    logic signed [FEAT_W-1:0] f;
    case (col)
      3'd0:    f = item.rel_pos_x;
      3'd1:    f = item.rel_pos_y;
      3'd2:    f = item.rel_pos_z;
      3'd3:    f = item.rel_vel_x;
      3'd4:    f = item.rel_vel_y;
      3'd5:    f = item.rel_vel_z;
      default: f = '0;
    endcase
    return f;
  endfunction

  // ReLU, round Q.24 to Q5.10, saturate
  function automatic logic [EMB_W-1:0] relu_round(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0]            rounded;
    logic [ACC_W-FRAC_SHIFT-1:0] r;
    logic [EMB_W-1:0]            y;
    rounded = ACC_W'(acc) + ACC_W'(ROUND_HALF);
    r       = rounded[ACC_W-1:FRAC_SHIFT];
    if (acc[ACC_W-1] || (acc == '0)) begin
      y = '0;
    end else if (r > (ACC_W-FRAC_SHIFT)'(Q_MAX)) begin
      y = EMB_W'(Q_MAX);
    end else begin
      y = r[EMB_W-1:0];
    end
    return y;
  endfunction

endpackage

// ===== rtl/core/nme_mlp.sv =====
// ----------------------------------------------------------------------------
// nme_mlp: shared multiply-accumulate datapath of the 6-8-8 network
// Operand fetch, registered multiply, accumulate, then ReLU/round. Hidden
// activations live in a small synchronous memory read back by layer 1.
// ----------------------------------------------------------------------------
module nme_mlp (
  input  logic              clk,
  input  logic              rst,
  input  nme_pkg::issue_t   issue,
  input  nme_pkg::in_item_t x,
  output nme_pkg::mlp_res_t res,
  output logic              busy
);
  import nme_pkg::*;

  issue_t                   s1;
  issue_t                   s2;
  issue_t                   s3;
  logic signed [FEAT_W:0]   s1_x;
  logic signed [COEF_W-1:0] s1_w;
  logic signed [FEAT_W:0]   op_a;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_base;
  logic [EMB_W-1:0]         hid_mem [HIDDEN_WIDTH];
  logic [EMB_W-1:0]         hid_rdata;
  logic [EMB_W-1:0]         y;
  logic                     hid_wr;

  // Advance the slot control through fetch, multiply and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else begin
      s1 <= issue;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // Layer 0 takes the observation, layer 1 the stored hidden value
  always_comb begin
    op_a     = s1.out_layer ? $signed({2'b00, hid_rdata}) : s1_x;
    acc_base = s2.first ? (ACC_W'(bias(s2.out_layer, s2.row)) <<< BIAS_SHIFT) : acc;
  end

  // Fetch operands, multiply, accumulate
  always_ff @(posedge clk) begin
    s1_x    <= (FEAT_W+1)'(feature(x, issue.col));
    s1_w    <= coef(issue.out_layer, issue.row, issue.col);
    s2_prod <= PROD_W'(op_a) * PROD_W'(s1_w);
    if (s2.vld) begin
      acc <= acc_base + ACC_W'(s2_prod);
    end
  end

  assign y      = relu_round(acc);
  assign hid_wr = s3.vld && s3.last && !s3.out_layer;

  // Hidden activation memory, one write and one read port
  always_ff @(posedge clk) begin
    if (hid_wr) begin
      hid_mem[s3.row] <= y;
    end
    hid_rdata <= hid_mem[issue.col];
  end

  always_comb begin
    res.vld   = s3.vld && s3.last && s3.out_layer;
    res.row   = s3.row;
    res.value = y;
  end

  assign busy = s1.vld || s2.vld || s3.vld;

endmodule

// ===== rtl/core/nme_pool.sv =====
// ----------------------------------------------------------------------------
// nme_pool: per-output accumulator memory and mean stage
// Read-modify-write of the eight sums, then a sweep that reads, clears and
// divides each sum by the set size through a reciprocal multiply.
// ----------------------------------------------------------------------------
module nme_pool #(
  parameter int unsigned NEIGHBORS = nme_pkg::NEIGHBORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  nme_pkg::mlp_res_t  res,
  input  nme_pkg::sweep_t    sweep,
  input  logic               out_ready,
  output logic               out_valid,
  output nme_pkg::out_item_t out_data,
  output logic               acc_busy
);
  import nme_pkg::*;

  // Set size stays below 2^CNT_W, so this shift makes the reciprocal exact
  localparam int unsigned DIV_SHIFT = SUM_W + CNT_W;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned MPROD_W   = SUM_W + RECIP_W;
  localparam int unsigned QUOT_W    = MPROD_W - DIV_SHIFT;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + 64'(NEIGHBORS) - 64'd1) / 64'(NEIGHBORS);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(HIDDEN_WIDTH - 1);

  logic [SUM_W-1:0]        sum_mem [HIDDEN_WIDTH];
  logic [HIDDEN_WIDTH-1:0] sum_vld;
  logic [IDX_W-1:0]        rd_addr;
  logic [SUM_W-1:0]        rd_data;
  logic                    rd_ok;
  logic [SUM_W-1:0]        sum_cur;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [SUM_W-1:0]        wr_data;
  mlp_res_t                pend;
  sweep_t                  m1;
  sweep_t                  m2;
  logic [MPROD_W-1:0]      m2_prod;
  logic [QUOT_W-1:0]       quot;
  logic [EMB_W-1:0]        emb [HIDDEN_WIDTH];

  // An entry never written since reset reads as zero
  assign sum_cur = rd_ok ? rd_data : '0;
  assign rd_addr = sweep.vld ? sweep.idx : res.row;

  // Write back the updated sum, or clear the entry being swept
  always_comb begin
    wr_en   = pend.vld || sweep.vld;
    wr_addr = pend.vld ? pend.row : sweep.idx;
    wr_data = pend.vld ? (sum_cur + SUM_W'(pend.value)) : '0;
  end

  // Accumulator memory, read first
  always_ff @(posedge clk) begin
    rd_data <= sum_mem[rd_addr];
    rd_ok   <= sum_vld[rd_addr];
    if (wr_en) begin
      sum_mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries and the sweep and update pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld   <= '0;
      pend      <= '0;
      m1        <= '0;
      m2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        sum_vld[wr_addr] <= 1'b1;
      end
      pend <= res;
      m1   <= sweep;
      m2   <= m1;
      if (m2.vld && (m2.idx == LAST_IDX)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign quot = m2_prod[MPROD_W-1:DIV_SHIFT];

  // Multiply by the reciprocal, then saturate into the output lanes
  always_ff @(posedge clk) begin
    m2_prod <= MPROD_W'(sum_cur) * MPROD_W'(RECIP);
    if (m2.vld) begin
      emb[m2.idx] <= (quot > QUOT_W'(Q_MAX)) ? EMB_W'(Q_MAX) : quot[EMB_W-1:0];
    end
  end

  always_comb begin
    out_data.embed_0 = emb[0];
    out_data.embed_1 = emb[1];
    out_data.embed_2 = emb[2];
    out_data.embed_3 = emb[3];
    out_data.embed_4 = emb[4];
    out_data.embed_5 = emb[5];
    out_data.embed_6 = emb[6];
    out_data.embed_7 = emb[7];
  end

  assign acc_busy = pend.vld;

endmodule

// ===== rtl/core/neighbor_mean_embedding_mlp.sv =====
// ----------------------------------------------------------------------------
// neighbor_mean_embedding_mlp: mean-pooled 6-8-8 ReLU encoder of neighbors
// Each observation takes 112 MAC slots on the one shared multiplier, a drain
// after layer 0 and a drain after layer 1. The item closing a set adds a
// hold state and a mean sweep over the eight sums, plus any wait for the
// previous result to be taken, and then presents its embedding on the output.
// Reset clears the sums and the count; one item is taken at a time.
// ----------------------------------------------------------------------------
module neighbor_mean_embedding_mlp #(
  parameter int unsigned NEIGHBORS = nme_pkg::NEIGHBORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nme_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nme_pkg::out_item_t out_data
);
  import nme_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HIDDEN_WIDTH - 1);
  localparam logic [IDX_W-1:0] LAST_FEAT = IDX_W'(INPUT_FEATURES - 1);
  localparam logic [CNT_W:0]   SET_SIZE  = (CNT_W+1)'(NEIGHBORS);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] row_next;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] col_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  in_item_t         in_q;
  issue_t           issue;
  sweep_t           sweep;
  mlp_res_t         res;
  logic             mlp_busy;
  logic             acc_busy;
  logic             col_last;
  logic             row_last;
  logic             set_close;
  logic             drained;

  assign col_last  = (state == S_LAYER0) ? (col == LAST_FEAT) : (col == LAST_IDX);
  assign row_last  = (row == LAST_IDX);
  assign set_close = ((CNT_W+1)'(count) + 1'b1) >= SET_SIZE;
  assign drained   = !mlp_busy && !acc_busy;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_LAYER0;
      S_LAYER0: if (row_last && col_last) state_next = S_DRAIN0;
      S_DRAIN0: if (!mlp_busy) state_next = S_LAYER1;
      S_LAYER1: if (row_last && col_last) state_next = S_DRAIN1;
      S_DRAIN1: if (drained) state_next = set_close ? S_HOLD : S_IDLE;
      S_HOLD:   if (!out_valid) state_next = S_MEAN;
      S_MEAN:   if (row_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake, MAC slot and sweep step
  always_comb begin
    in_ready        = (state == S_IDLE);
    issue.vld       = (state == S_LAYER0) || (state == S_LAYER1);
    issue.out_layer = (state == S_LAYER1);
    issue.first     = (col == '0);
    issue.last      = col_last;
    issue.row       = row;
    issue.col       = col;
    sweep.vld       = (state == S_MEAN);
    sweep.idx       = row;
  end

  // Walk rows and columns; count items of the set
  always_comb begin
    row_next   = row;
    col_next   = col;
    count_next = count;
    case (state) inside
      S_LAYER0, S_LAYER1: begin
        if (col_last) begin
          col_next = '0;
          row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_MEAN: begin
        row_next = row + 1'b1;
      end
      S_DRAIN1: begin
        if (drained) begin
          count_next = set_close ? '0 : count + 1'b1;
        end
      end
      default: begin
        row_next = row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      count <= count_next;
    end
  end

  // Hold the observation for the whole pass
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  nme_mlp u_mlp (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .x     (in_q),
    .res   (res),
    .busy  (mlp_busy)
  );

  nme_pool #(
    .NEIGHBORS (NEIGHBORS)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .sweep     (sweep),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .acc_busy  (acc_busy)
  );

`ifndef ASSERT_OFF
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mlp_busy && !acc_busy))
    else $error("datapath still busy while idle");

  a_res_window: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> ((state == S_LAYER1) || (state == S_DRAIN1)))
    else $error("output neuron finished outside layer 1");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ((CNT_W+1)'(count) < SET_SIZE))
    else $error("neighbor count reached set size");

  a_sweep_free: assert property (@(posedge clk) disable iff (rst)
    sweep.vld |-> !out_valid)
    else $error("mean sweep while result register is full");
`endif

endmodule
